### hw/rtl/oapp_pkg.sv
// Shared constants and types of the open-addressing probe unit.
package oapp_pkg;

    localparam int TABLE_LOG2_DEF = 14;
    localparam int KEY_W          = 31;
    localparam int SLOT_OUT_W     = 14;
    localparam int PROBE_OUT_W    = 15;
    localparam int PROBE_MAX      = 32767;
    localparam int PERTURB_SHIFT  = 5;
    localparam int CHAIN_MARGIN   = 40;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic {
        ACT_QUERY  = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    // One queued item as the back end sees it.
    typedef struct packed {
        logic               is_insert;
        logic [KEY_W-1:0]   key;
    } item_t;

    // Control from the probe engine back to the front end.
    typedef struct packed {
        logic clearing;
        logic pop;
    } back_to_front_t;

endpackage

### hw/rtl/oapp_if.sv
// Valid/ready channel interfaces for the probe unit's items and results.
interface oapp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [oapp_pkg::KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface oapp_out_if;
    logic                             valid;
    logic                             ready;
    logic [oapp_pkg::SLOT_OUT_W-1:0]  slot;
    logic [oapp_pkg::PROBE_OUT_W-1:0] probe_count;
    logic                             table_full;

    modport source (output valid, output slot, output probe_count, output table_full,
                    input ready);
    modport sink   (input valid, input slot, input probe_count, input table_full,
                    output ready);
endinterface

### hw/rtl/open_addressing_perturb_probe_top.sv
// Top level of the open-addressing probe unit with hash perturbation.
//
// query channel: one beat per item, carrying action (0 query, 1 insert) and a
// 31-bit key. result channel: one beat per item, in order, carrying the first
// free slot on the key's probe chain, the number of probes (saturating) and
// table_full, which is set with slot and probe_count zero when no slot is free.
// The probe engine takes one item at a time from the queue and walks its chain
// through a single bitmap read port, one probe per cycle; a full table answers
// without probing.
// After reset the bitmap is cleared one slot a cycle, with query.ready held low
// throughout.
// A two-entry queue sits between the query side and the engine, and the result
// is held in an output register: when result.ready is low the result holds,
// the engine waits, the queue fills and then query.ready falls.
module open_addressing_perturb_probe_top #(
    parameter int TABLE_LOG2 = oapp_pkg::TABLE_LOG2_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    oapp_in_if.sink     query,
    oapp_out_if.source  result
);

    oapp_pkg::back_to_front_t to_front;
    oapp_pkg::item_t          head_item;
    logic                     head_valid;

    oapp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .to_front   (to_front),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    oapp_back #(
        .TABLE_LOG2 (TABLE_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .to_front   (to_front),
        .result     (result)
    );

endmodule

### hw/rtl/oapp_ram.sv
// Generic simple dual-port RAM with registered read.
module oapp_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/oapp_front.sv
// Front end: takes item beats, decodes the action and holds them in a short queue.
module oapp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    oapp_in_if.sink                    query,
    input  oapp_pkg::back_to_front_t   to_front,
    output logic                       head_valid,
    output oapp_pkg::item_t            head_item
);

    localparam int DEPTH = oapp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    oapp_pkg::item_t    entry_reg [DEPTH];
    oapp_pkg::item_t    new_item;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push;
    logic               pop;

    // Hold off new beats while the bitmap is being cleared or the queue is full.
    assign query.ready = (fill_reg != CNT_W'(DEPTH)) && !to_front.clearing;
    assign push        = query.valid && query.ready;
    assign pop         = to_front.pop && (fill_reg != '0);

    always_comb
    begin
        new_item.is_insert = (query.action == oapp_pkg::ACT_INSERT);
        new_item.key       = query.key;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head_valid = (fill_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("item queue overfilled");

endmodule

### hw/rtl/oapp_back.sv
// Back end: clears the occupancy bitmap, walks probe chains and registers results.
module oapp_back #(
    parameter int TABLE_LOG2 = oapp_pkg::TABLE_LOG2_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  oapp_pkg::item_t            head_item,
    output oapp_pkg::back_to_front_t   to_front,
    oapp_out_if.source                 result
);

    localparam int SLOT_COUNT = 1 << TABLE_LOG2;
    localparam int CNT_W      = TABLE_LOG2 + 1;
    localparam int PROBE_W    = TABLE_LOG2 + 7;
    localparam logic [CNT_W-1:0]      FULL_COUNT  = CNT_W'(SLOT_COUNT);
    localparam logic [TABLE_LOG2-1:0] LAST_SLOT   = '1;
    localparam logic [PROBE_W-1:0]    PROBE_LIMIT =
        PROBE_W'(SLOT_COUNT + oapp_pkg::CHAIN_MARGIN);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_PROBE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [TABLE_LOG2-1:0]           clr_reg, clr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [TABLE_LOG2-1:0]           slot_reg, slot_next;
    logic [oapp_pkg::KEY_W-1:0]      perturb_reg, perturb_next;
    logic [PROBE_W-1:0]              probes_reg, probes_next;
    logic                            insert_reg, insert_next;
    logic                            out_valid_reg, out_valid_next;
    logic [oapp_pkg::SLOT_OUT_W-1:0] out_slot_reg;
    logic [oapp_pkg::PROBE_OUT_W-1:0] out_probes_reg;
    logic                            out_full_reg;

    logic                            load;
    logic [oapp_pkg::SLOT_OUT_W-1:0] load_slot;
    logic [oapp_pkg::PROBE_OUT_W-1:0] load_probes;
    logic                            load_full;
    logic                            out_free;
    logic [oapp_pkg::KEY_W-1:0]      perturb_shifted;
    logic [TABLE_LOG2-1:0]           slot_step;

    logic                            ram_we;
    logic [TABLE_LOG2-1:0]           ram_waddr;
    logic                            ram_wdata;
    logic                            ram_re;
    logic [TABLE_LOG2-1:0]           ram_raddr;
    logic                            ram_rdata;

    oapp_ram #(
        .WIDTH (1),
        .DEPTH (SLOT_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free        = !out_valid_reg || result.ready;
    assign perturb_shifted = perturb_reg >> oapp_pkg::PERTURB_SHIFT;
    // slot*5 + 1 + perturbation, wrapped to the table size
    assign slot_step = (slot_reg << 2) + slot_reg + TABLE_LOG2'(1)
                     + perturb_shifted[TABLE_LOG2-1:0];

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        perturb_next = perturb_reg;
        probes_next  = probes_reg;
        insert_next  = insert_reg;
        to_front     = '{clearing: 1'b0, pop: 1'b0};
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = 1'b1;
        ram_re       = 1'b0;
        ram_raddr    = slot_reg;
        load         = 1'b0;
        load_slot    = '0;
        load_probes  = '0;
        load_full    = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                to_front.clearing = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = clr_reg + TABLE_LOG2'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    to_front.pop = 1'b1;
                    if (count_reg == FULL_COUNT)
                    begin
                        load      = 1'b1;
                        load_full = 1'b1;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = head_item.key[TABLE_LOG2-1:0];
                        slot_next    = head_item.key[TABLE_LOG2-1:0];
                        perturb_next = head_item.key;
                        probes_next  = PROBE_W'(1);
                        insert_next  = head_item.is_insert;
                        state_next   = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (ram_rdata == 1'b0)
                begin
                    load      = 1'b1;
                    load_slot = oapp_pkg::SLOT_OUT_W'(slot_reg);
                    if (32'(probes_reg) > 32'(oapp_pkg::PROBE_MAX))
                    begin
                        load_probes = oapp_pkg::PROBE_OUT_W'(oapp_pkg::PROBE_MAX);
                    end
                    else
                    begin
                        load_probes = oapp_pkg::PROBE_OUT_W'(probes_reg);
                    end
                    if (insert_reg)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
                else if (probes_reg == PROBE_LIMIT)
                begin
                    load       = 1'b1;
                    load_full  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Issue the next bitmap read straight away: one probe a cycle.
                    perturb_next = perturb_shifted;
                    slot_next    = slot_step;
                    ram_re       = 1'b1;
                    ram_raddr    = slot_step;
                    probes_next  = probes_reg + PROBE_W'(1);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        perturb_reg <= perturb_next;
        probes_reg  <= probes_next;
        insert_reg  <= insert_next;
        if (load)
        begin
            out_slot_reg   <= load_slot;
            out_probes_reg <= load_probes;
            out_full_reg   <= load_full;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.slot        = out_slot_reg;
    assign result.probe_count = out_probes_reg;
    assign result.table_full  = out_full_reg;

    count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("occupancy count beyond table size");

    no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !to_front.pop)
        else $error("item taken during bitmap clear");

    no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !load)
        else $error("pending result overwritten");

    insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && ram_rdata == 1'b0 && insert_reg)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance occupancy count");

endmodule

### tb/oapp_probe_checker.sv
`timescale 1ns / 100ps
// Bitmap tracker and in-order comparison of the probe unit's result beats.
module oapp_probe_checker #(
    parameter int TABLE_LOG2 = oapp_pkg::TABLE_LOG2_DEF
) (
    input  logic clk,
    input  logic rst_n,
    oapp_in_if   query,
    oapp_out_if  result,
    output int   fail_count,
    output int   pending
);

    localparam int          SLOTS     = 1 << TABLE_LOG2;
    localparam logic [31:0] SLOT_MASK = 32'(SLOTS - 1);
    localparam int          MAX_SHOWN = 10;

    typedef struct packed {
        logic [oapp_pkg::SLOT_OUT_W-1:0]  slot;
        logic [oapp_pkg::PROBE_OUT_W-1:0] probe_count;
        logic                             table_full;
    } probe_answer_t;

    bit            occupied [SLOTS];
    int unsigned   filled;
    probe_answer_t expected_answers [$];
    probe_answer_t head;
    int            failures;
    int            shown;

    // Walk the perturbed chain from the key's home slot; claim the free slot on insert.
    function automatic probe_answer_t probe_chain(input logic is_insert,
                                                  input logic [oapp_pkg::KEY_W-1:0] key);
        logic [31:0]   perturb;
        logic [31:0]   slot;
        int unsigned   probes;
        bit            found;
        probe_answer_t answer;
        perturb = 32'(key);
        slot    = perturb & SLOT_MASK;
        probes  = 1;
        found   = 1'b0;
        answer  = '0;
        if (filled < SLOTS)
        begin
            while (!found && probes <= SLOTS + oapp_pkg::CHAIN_MARGIN)
            begin
                if (!occupied[slot])
                begin
                    found = 1'b1;
                end
                else
                begin
                    perturb = perturb >> oapp_pkg::PERTURB_SHIFT;
                    slot    = (slot * 5 + 1 + perturb) & SLOT_MASK;
                    probes++;
                end
            end
        end
        if (found)
        begin
            if (is_insert)
            begin
                occupied[slot] = 1'b1;
                filled++;
            end
            answer.slot        = slot[oapp_pkg::SLOT_OUT_W-1:0];
            answer.probe_count = (probes > oapp_pkg::PROBE_MAX)
                               ? oapp_pkg::PROBE_OUT_W'(oapp_pkg::PROBE_MAX)
                               : oapp_pkg::PROBE_OUT_W'(probes);
        end
        else
        begin
            answer.table_full = 1'b1;
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (occupied[i])
                occupied[i] = 1'b0;
            filled = 0;
            expected_answers.delete();
            failures = 0;
            shown    = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Take the result beat first: it can never answer a query taken at the same edge.
            if (result.valid && result.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    failures++;
                    if (shown < MAX_SHOWN)
                        $display("result beat with nothing expected: slot %0d probes %0d full %0b",
                                 result.slot, result.probe_count, result.table_full);
                    shown++;
                end
                else
                begin
                    head = expected_answers.pop_front();
                    if (result.slot !== head.slot || result.probe_count !== head.probe_count ||
                        result.table_full !== head.table_full)
                    begin
                        failures++;
                        if (shown < MAX_SHOWN)
                        begin
                            $write("result mismatch: expected slot %0d probes %0d full %0b",
                                   head.slot, head.probe_count, head.table_full);
                            $display(", got slot %0d probes %0d full %0b",
                                     result.slot, result.probe_count, result.table_full);
                        end
                        shown++;
                    end
                end
            end
            if (query.valid && query.ready)
                expected_answers.push_back(probe_chain(query.action, query.key));
            fail_count <= failures;
            pending    <= expected_answers.size();
        end
    end

endmodule

### tb/tb_open_addressing_perturb_probe_top.sv
`timescale 1ns / 100ps
// Stimulus, result back-pressure, watchdog and verdict for the probe unit.
module tb_open_addressing_perturb_probe_top;

    localparam int SLOTS            = 1 << oapp_pkg::TABLE_LOG2_DEF;
    localparam int WATCHDOG_LIMIT   = 100000;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 64;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int RECENT_DEPTH     = 32;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_off;
    int   quiet_cycles   = 0;
    logic [oapp_pkg::KEY_W-1:0] recent_keys [$];

    oapp_in_if  query_ch ();
    oapp_out_if result_ch ();

    open_addressing_perturb_probe_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    oapp_probe_checker probe_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // Offer one beat after a random gap and hold it until taken.
    task automatic offer(input oapp_pkg::action_t act, input logic [oapp_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid  <= 1'b1;
        query_ch.action <= act;
        query_ch.key    <= key;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        recent_keys.push_back(key);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endtask

    // Mix wide keys, crowded home slots and repeats so that chains grow.
    function automatic logic [oapp_pkg::KEY_W-1:0] pick_key();
        int unsigned                sel;
        logic [oapp_pkg::KEY_W-1:0] key;
        sel = $urandom_range(99);
        key = oapp_pkg::KEY_W'($urandom);
        if (sel < 30)
            key[13:0] = 14'($urandom_range(15));
        else if (sel < 50 && recent_keys.size() > 0)
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else if (sel < 60)
            key = oapp_pkg::KEY_W'($urandom_range(SLOTS - 1));
        return key;
    endfunction

    task automatic random_burst(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 60)
                offer(oapp_pkg::ACT_INSERT, pick_key());
            else
                offer(oapp_pkg::ACT_QUERY, pick_key());
        end
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold the result side off long enough for the queue to fill and the input to stall.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_open_addressing_perturb_probe_top failed");
            $finish;
        end
    end

    initial
    begin
        query_ch.valid  = 1'b0;
        query_ch.action = oapp_pkg::ACT_QUERY;
        query_ch.key    = '0;
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then repeated home slot zero to build a perturbed chain
        offer(oapp_pkg::ACT_QUERY, '0);
        offer(oapp_pkg::ACT_INSERT, '0);
        offer(oapp_pkg::ACT_QUERY, '0);
        offer(oapp_pkg::ACT_INSERT, '0);
        offer(oapp_pkg::ACT_INSERT, '0);
        offer(oapp_pkg::ACT_INSERT, oapp_pkg::KEY_W'(SLOTS));
        offer(oapp_pkg::ACT_INSERT, 31'h7FFF_C000);
        offer(oapp_pkg::ACT_QUERY, oapp_pkg::KEY_W'(SLOTS));
        // widest key and top slot
        offer(oapp_pkg::ACT_INSERT, '1);
        offer(oapp_pkg::ACT_QUERY, '1);
        offer(oapp_pkg::ACT_INSERT, '1);
        offer(oapp_pkg::ACT_INSERT, oapp_pkg::KEY_W'(SLOTS - 1));
        offer(oapp_pkg::ACT_QUERY, oapp_pkg::KEY_W'(SLOTS - 1));
        offer(oapp_pkg::ACT_INSERT, 31'h5555_5555);
        offer(oapp_pkg::ACT_INSERT, 31'h2AAA_AAAA);
        offer(oapp_pkg::ACT_QUERY, 31'h4000_0000);
        offer(oapp_pkg::ACT_INSERT, 31'h0000_0020);
        offer(oapp_pkg::ACT_INSERT, 31'h0000_0001);

        set_idling(0, 0);
        hold_req = 1'b1;
        random_burst(RANDOM_PER_PHASE);
        set_idling(63, 0);
        random_burst(RANDOM_PER_PHASE);
        set_idling(0, 63);
        random_burst(RANDOM_PER_PHASE);
        set_idling(27, 27);
        random_burst(RANDOM_PER_PHASE);

        set_idling(27, 27);
        random_burst(12);

        query_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_open_addressing_perturb_probe_top passed");
        else
            $display("tb_open_addressing_perturb_probe_top failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/oapp_pkg.sv
hw/rtl/oapp_if.sv
hw/rtl/oapp_ram.sv
hw/rtl/oapp_front.sv
hw/rtl/oapp_back.sv
hw/rtl/open_addressing_perturb_probe_top.sv
tb/oapp_probe_checker.sv
tb/tb_open_addressing_perturb_probe_top.sv
